/* src/assert_macros.svh */
// Assertion macros used by the checker file of the sorted priority list.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the house clock and reset names.
`define ASSERT_STD(label, prop, msg) `ASSERT_CLKD(label, clk_i, rst_ni, prop, msg)

`endif

/* src/spl_pkg.sv */
// Types and constants of the sorted priority list.
// No dependencies; used by the interfaces, all modules and the checker.
package spl_pkg;

  localparam int ACT_W  = 3;
  localparam int ITEM_W = 32;
  localparam int KEY_W  = 32;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 5;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef enum logic [ACT_W-1:0] {
    ACT_PREPEND      = 3'd0,
    ACT_APPEND       = 3'd1,
    ACT_SORTED       = 3'd2,
    ACT_REMOVE_FIRST = 3'd3,
    ACT_REMOVE_KEY   = 3'd4
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    take;     // latch the request payload
    logic    start;    // load the scan pointer and clear scan flags
    logic    back;     // scan runs from the tail toward the head
    logic    res_set;  // clear the result and set its status
    status_e res_st;
    logic    step;     // advance the scan pointer
    logic    scan;     // evaluate the entry read in the previous cycle
    logic    fin_rm;   // close a removal at the last entry
    logic    put;      // write the new entry of an insert
    logic    out_load; // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic is_ins;   // latched request is an insert
    logic hit;      // insert: entry moves up; remove: entry matches
    logic at_end;   // entry under evaluation is the last of the scan
    logic out_free; // output register can take a result
  } stat_t;

endpackage

/* src/spl_if.sv */
// Request and response channel interfaces of the sorted priority list.
// Depends on spl_pkg.
interface spl_req_if import spl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [ITEM_W-1:0]        item_in;
  logic signed [KEY_W-1:0]  key_in;

  modport source (output valid, action, item_in, key_in, input ready);
  modport sink   (input valid, action, item_in, key_in, output ready);
endinterface

interface spl_rsp_if import spl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ITEM_W-1:0]        item_out;
  logic signed [KEY_W-1:0]  key_out;
  logic [ST_W-1:0]          status;
  logic [CNT_W-1:0]         entry_count;

  modport source (output valid, item_out, key_out, status, entry_count, input ready);
  modport sink   (input valid, item_out, key_out, status, entry_count, output ready);
endinterface

/* src/sorted_priority_list_top.sv */
// Sorted priority list: one request at a time. The time from acceptance until the next
// request can be taken, and until the result is valid, depends on the number of entries
// held, set by the one-entry-per-cycle scan of the entry memory. A rejected insert, a
// removal from an empty list and an unused code skip the scan, and so does an insert
// into an empty list, which writes its entry directly. A result may wait at the
// output while the next request runs. Reset (async, active low) empties the list.
module sorted_priority_list_top import spl_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spl_req_if.sink    req_i,
  spl_rsp_if.source  rsp_o
);

  cmd_t  cmd;
  stat_t stat;

  spl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.action),
    .req_ready_o  (req_i.ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  spl_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .action_i     (req_i.action),
    .item_i       (req_i.item_in),
    .key_i        (req_i.key_in),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_item_o   (rsp_o.item_out),
    .rsp_key_o    (rsp_o.key_out),
    .rsp_status_o (rsp_o.status),
    .rsp_count_o  (rsp_o.entry_count)
  );

endmodule

/* src/spl_datapath.sv */
// Datapath of the sorted priority list: entry memory, scan pointer, fill count,
// result staging and output register. Depends on spl_pkg.
module spl_datapath import spl_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output stat_t                   stat_o,
  input  logic [ACT_W-1:0]        action_i,
  input  logic [ITEM_W-1:0]       item_i,
  input  logic signed [KEY_W-1:0] key_i,
  output logic                    rsp_valid_o,
  input  logic                    rsp_ready_i,
  output logic [ITEM_W-1:0]       rsp_item_o,
  output logic signed [KEY_W-1:0] rsp_key_o,
  output logic [ST_W-1:0]         rsp_status_o,
  output logic [CNT_W-1:0]        rsp_count_o
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [KEY_W-1:0] key_mem  [DEPTH];
  logic [ITEM_W-1:0]       item_mem [DEPTH];

  logic [CW-1:0]           count_q, count_d;
  logic                    found_q, found_d;
  logic                    out_vld_q, out_vld_d;

  action_e                 act_q;
  logic [ITEM_W-1:0]       item_q;
  logic signed [KEY_W-1:0] key_q;
  logic [IW-1:0]           ptr_q, rptr_q, pos_q;
  logic signed [KEY_W-1:0] rd_key_q, base_q;
  logic [ITEM_W-1:0]       rd_item_q;
  logic [ITEM_W-1:0]       res_item_q;
  logic signed [KEY_W-1:0] res_key_q;
  status_e                 res_st_q;
  logic [ITEM_W-1:0]       out_item_q;
  logic signed [KEY_W-1:0] out_key_q;
  status_e                 out_st_q;
  logic [CNT_W-1:0]        out_cnt_q;

  logic                    is_ins, hit, at_end;
  logic signed [KEY_W-1:0] new_key;
  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_key;
  logic [ITEM_W-1:0]       wr_item;
  logic [IW-1:0]           last_idx;

  assign last_idx = IW'(count_q - CW'(1));
  assign is_ins   = (act_q == ACT_PREPEND) || (act_q == ACT_APPEND) || (act_q == ACT_SORTED);

  // Inserts walk from the tail: an entry moves up while its key is above the new one.
  // Removals walk from the head looking for the first match.
  always_comb begin
    hit = 1'b0;
    case (act_q)
      ACT_PREPEND:      hit = 1'b1;
      ACT_APPEND:       hit = 1'b0;
      ACT_SORTED:       hit = (rd_key_q > key_q);
      ACT_REMOVE_FIRST: hit = 1'b1;
      ACT_REMOVE_KEY:   hit = (rd_key_q == key_q);
      default:          hit = 1'b0;
    endcase
  end

  assign at_end = is_ins ? (rptr_q == '0) : (rptr_q == last_idx);

  always_comb begin
    new_key = key_q;
    case (act_q)
      ACT_PREPEND: begin
        if (count_q == '0)          new_key = '0;
        else if (base_q == KEY_MIN) new_key = base_q;
        else                        new_key = base_q - KEY_W'(1);
      end
      ACT_APPEND: begin
        if (count_q == '0)          new_key = '0;
        else if (base_q == KEY_MAX) new_key = base_q;
        else                        new_key = base_q + KEY_W'(1);
      end
      default: new_key = key_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_key  = rd_key_q;
    wr_item = rd_item_q;
    if (cmd_i.put) begin
      wr_en   = 1'b1;
      wr_key  = new_key;
      wr_item = item_q;
    end else if (cmd_i.scan) begin
      if (is_ins && hit) begin
        wr_en   = 1'b1;
        wr_addr = rptr_q + IW'(1);
      end else if (!is_ins && found_q) begin
        wr_en   = 1'b1;
        wr_addr = rptr_q - IW'(1);
      end
    end
  end

  // The read port runs every cycle; the controller decides when its data counts.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      item_mem[wr_addr] <= wr_item;
    end
    rd_key_q  <= key_mem[ptr_q];
    rd_item_q <= item_mem[ptr_q];
  end

  always_comb begin
    count_d   = count_q;
    found_d   = found_q;
    out_vld_d = out_vld_q;
    if (cmd_i.start) found_d = 1'b0;
    if (cmd_i.scan && !is_ins && hit) found_d = 1'b1;
    if (cmd_i.put) count_d = count_q + CW'(1);
    if (cmd_i.fin_rm && (found_q || hit)) count_d = count_q - CW'(1);
    if (cmd_i.out_load)  out_vld_d = 1'b1;
    else if (rsp_ready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rptr_q <= ptr_q;
    if (cmd_i.take) begin
      act_q  <= action_e'(action_i);
      item_q <= item_i;
      key_q  <= key_i;
    end
    if (cmd_i.start) begin
      ptr_q <= cmd_i.back ? last_idx : '0;
      pos_q <= '0;
    end else if (cmd_i.step) begin
      ptr_q <= is_ins ? ptr_q - IW'(1) : ptr_q + IW'(1);
    end
    if (cmd_i.res_set) begin
      res_item_q <= '0;
      res_key_q  <= '0;
      res_st_q   <= cmd_i.res_st;
    end
    if (cmd_i.scan) begin
      if (is_ins) begin
        base_q <= rd_key_q;
        if (!hit) pos_q <= rptr_q + IW'(1);
      end else if (!found_q && hit) begin
        res_item_q <= rd_item_q;
        res_key_q  <= rd_key_q;
      end
    end
    if (cmd_i.fin_rm && !(found_q || hit)) res_st_q <= ST_MISS;
    if (cmd_i.put) res_key_q <= new_key;
    if (cmd_i.out_load) begin
      out_item_q <= res_item_q;
      out_key_q  <= res_key_q;
      out_st_q   <= res_st_q;
      out_cnt_q  <= CNT_W'(count_q);
    end
  end

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.count_full = (count_q == CW'(DEPTH));
  assign stat_o.is_ins     = is_ins;
  assign stat_o.hit        = hit;
  assign stat_o.at_end     = at_end;
  assign stat_o.out_free   = !out_vld_q || rsp_ready_i;

  assign rsp_valid_o  = out_vld_q;
  assign rsp_item_o   = out_item_q;
  assign rsp_key_o    = out_key_q;
  assign rsp_status_o = out_st_q;
  assign rsp_count_o  = out_cnt_q;

endmodule

/* src/spl_ctrl.sv */
// Controller of the sorted priority list: sequences one request through
// read priming, the entry scan, the insert write and the result hand-off.
// Depends on spl_pkg.
module spl_ctrl import spl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic [ACT_W-1:0] req_action_i,
  output logic             req_ready_o,
  input  stat_t            stat_i,
  output cmd_t             cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PRIME = 5'b00010,
    S_SCAN  = 5'b00100,
    S_PUT   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   req_ins, req_rm;

  assign req_ins = req_action_i inside {ACT_PREPEND, ACT_APPEND, ACT_SORTED};
  assign req_rm  = req_action_i inside {ACT_REMOVE_FIRST, ACT_REMOVE_KEY};

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.res_st = ST_OK;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.take    = 1'b1;
          cmd_o.start   = 1'b1;
          cmd_o.back    = req_ins;
          cmd_o.res_set = 1'b1;
          if (req_ins) begin
            if (stat_i.count_full) begin
              cmd_o.res_st = ST_FULL;
              state_d      = S_OUT;
            end else if (stat_i.count_zero) begin
              state_d = S_PUT;
            end else begin
              state_d = S_PRIME;
            end
          end else if (req_rm) begin
            if (stat_i.count_zero) begin
              cmd_o.res_st = ST_MISS;
              state_d      = S_OUT;
            end else begin
              state_d = S_PRIME;
            end
          end else begin
            // Unused action codes leave the list alone.
            state_d = S_OUT;
          end
        end
      end
      S_PRIME: begin
        cmd_o.step = 1'b1;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        cmd_o.step = 1'b1;
        if (stat_i.is_ins) begin
          if (!stat_i.hit || stat_i.at_end) state_d = S_PUT;
        end else if (stat_i.at_end) begin
          cmd_o.fin_rm = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/spl_checker.sv */
// Port-level checks of the sorted priority list, bound to the top level.
// Depends on spl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spl_checker import spl_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_valid_i,
  input logic                    req_ready_i,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input logic [ITEM_W-1:0]       rsp_item_i,
  input logic signed [KEY_W-1:0] rsp_key_i,
  input logic [ST_W-1:0]         rsp_status_i,
  input logic [CNT_W-1:0]        rsp_count_i
);

  // A stalled result keeps its contents.
  `ASSERT_STD(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_key_i) && $stable(rsp_item_i), "stalled result changed")

  // One request at a time: the request side closes right after a request.
  `ASSERT_STD(a_one_at_a_time, req_valid_i && req_ready_i |=> !req_ready_i, "request taken while busy")

  // Failed requests report no entry.
  `ASSERT_STD(a_fail_zero, rsp_valid_i && (rsp_status_i != ST_OK) |-> (rsp_item_i == '0) && (rsp_key_i == '0), "failed request reports an entry")

  // A rejected insert means the list holds DEPTH entries.
  `ASSERT_STD(a_full_count, rsp_valid_i && (rsp_status_i == ST_FULL) |-> rsp_count_i == CNT_W'(DEPTH), "full status with short list")

endmodule

bind sorted_priority_list_top spl_checker #(.DEPTH(DEPTH)) u_spl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_item_i   (rsp_o.item_out),
  .rsp_key_i    (rsp_o.key_out),
  .rsp_status_i (rsp_o.status),
  .rsp_count_i  (rsp_o.entry_count)
);
